@@ hw/rtl/rpj_pkg.sv @@
// Shared types and constants of the disparity to point reprojection block.
`default_nettype none
package rpj_pkg;

  // Magnitude of a numerator product, of the disparity and of a partial remainder.
  localparam int NumW = 36;
  localparam int DivW = 16;
  localparam int RemW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 20;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_FOCAL = 3'd0,
    REG_CCOL  = 3'd1,
    REG_CROW  = 3'd2,
    REG_BASE  = 3'd3,
    REG_INVD  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]        focal;
    logic [15:0]        ccol;
    logic [15:0]        crow;
    logic [19:0]        base;
    logic signed [15:0] invd;
  } cfg_t;

  // Word as it travels through the divider stages.
  typedef struct packed {
    logic [11:0]        col;
    logic [11:0]        row;
    logic signed [15:0] disp;
    logic [7:0]         gray;
    logic               invalid;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
    logic [DivW-1:0]    dmag;
    logic [NumW-1:0]    nq_x;
    logic [NumW-1:0]    nq_y;
    logic [NumW-1:0]    nq_z;
    logic [RemW-1:0]    r_x;
    logic [RemW-1:0]    r_y;
    logic [RemW-1:0]    r_z;
  } pipe_t;

endpackage
`default_nettype wire

@@ hw/rtl/rpj_front.sv @@
// Front stages: offset differences, invalid test, products and sign split.
`default_nettype none
module rpj_front import rpj_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        in_valid,
  input  wire logic [47:0] in_data,
  input  wire cfg_t        cfg,
  output logic             out_valid,
  output pipe_t            out_word
);

  logic               a_valid;
  logic [11:0]        a_col;
  logic [11:0]        a_row;
  logic signed [15:0] a_disp;
  logic [7:0]         a_gray;
  logic               a_invalid;
  logic signed [17:0] a_dx;
  logic signed [17:0] a_dy;

  logic signed [15:0] in_disp;
  logic [16:0]        dx_mag;
  logic [16:0]        dy_mag;
  logic [16:0]        d_mag;

  assign in_disp = in_data[39:24];

  // Stage A: register the word, form the signed offsets and test the disparity.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
    if (adv) begin
      a_col     <= in_data[11:0];
      a_row     <= in_data[23:12];
      a_disp    <= in_disp;
      a_gray    <= in_data[47:40];
      a_invalid <= (in_disp == 16'sd0) || (in_disp == cfg.invd);
      a_dx      <= $signed({2'b00, in_data[11:0], 4'b0000}) - $signed({2'b00, cfg.ccol});
      a_dy      <= $signed({2'b00, in_data[23:12], 4'b0000}) - $signed({2'b00, cfg.crow});
    end
  end

  // Magnitudes for the unsigned products and the unsigned divider.
  always_comb begin
    dx_mag = a_dx[17] ? 17'(-a_dx) : a_dx[16:0];
    dy_mag = a_dy[17] ? 17'(-a_dy) : a_dy[16:0];
    d_mag  = a_disp[15] ? 17'(-$signed({a_disp[15], a_disp})) : {1'b0, a_disp};
  end

  // Stage B: one multiplier per coordinate, signs carried beside.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= a_valid;
    end
    if (adv) begin
      out_word.col     <= a_col;
      out_word.row     <= a_row;
      out_word.disp    <= a_disp;
      out_word.gray    <= a_gray;
      out_word.invalid <= a_invalid;
      out_word.neg_x   <= a_dx[17] ^ a_disp[15];
      out_word.neg_y   <= a_dy[17] ^ a_disp[15];
      out_word.neg_z   <= a_disp[15];
      out_word.dmag    <= d_mag[DivW-1:0];
      out_word.nq_x    <= NumW'(dx_mag[15:0]) * NumW'(cfg.base);
      out_word.nq_y    <= NumW'(dy_mag[15:0]) * NumW'(cfg.base);
      out_word.nq_z    <= NumW'(cfg.focal) * NumW'(cfg.base);
      out_word.r_x     <= '0;
      out_word.r_y     <= '0;
      out_word.r_z     <= '0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/rpj_div_step.sv @@
// One restoring division step for the three coordinate lanes.
`default_nettype none
module rpj_div_step import rpj_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic in_valid,
  input  wire pipe_t in_word,
  output logic      out_valid,
  output pipe_t     out_word
);

  pipe_t nxt;

  // Shift the next numerator bit into the remainder, subtract when it fits,
  // and shift the quotient bit in where the numerator bit left.
  function automatic logic [RemW+NumW-1:0] step(input logic [RemW-1:0] r,
                                               input logic [NumW-1:0] nq,
                                               input logic [DivW-1:0] d);
    logic [RemW-1:0] trial;
    logic            ge;
    trial = {r[RemW-2:0], nq[NumW-1]};
    ge    = trial >= d;
    return {(ge ? trial - d : trial), nq[NumW-2:0], ge};
  endfunction

  always_comb begin
    nxt = in_word;
    {nxt.r_x, nxt.nq_x} = step(in_word.r_x, in_word.nq_x, in_word.dmag);
    {nxt.r_y, nxt.nq_y} = step(in_word.r_y, in_word.nq_y, in_word.dmag);
    {nxt.r_z, nxt.nq_z} = step(in_word.r_z, in_word.nq_z, in_word.dmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_word <= nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/rpj_sat.sv @@
// Output stage: sign restore, clipping to 32 bits and the output register.
`default_nettype none
module rpj_sat import rpj_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   adv,
  input  wire logic   in_valid,
  input  wire pipe_t  in_word,
  output logic        out_valid,
  output logic [143:0] out_data,
  output logic [1:0]  out_user
);

  logic [31:0] x_c, y_c, z_c;
  logic        sx, sy, sz;

  function automatic logic [32:0] clip(input logic [NumW-1:0] q, input logic neg);
    if (neg) begin
      if (q > NumW'(36'h080000000)) return {1'b1, 32'h80000000};
      return {1'b0, 32'(32'd0 - q[31:0])};
    end
    if (q > NumW'(36'h07FFFFFFF)) return {1'b1, 32'h7FFFFFFF};
    return {1'b0, q[31:0]};
  endfunction

  always_comb begin
    {sx, x_c} = clip(in_word.nq_x, in_word.neg_x);
    {sy, y_c} = clip(in_word.nq_y, in_word.neg_y);
    {sz, z_c} = clip(in_word.nq_z, in_word.neg_z);
    if (in_word.invalid) begin
      x_c = 32'h7FFFFFFF;
      y_c = 32'h7FFFFFFF;
      z_c = 32'h7FFFFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_data <= {in_word.gray, in_word.disp, in_word.row, in_word.col, z_c, y_c, x_c};
      out_user <= {in_word.invalid | sx | sy | sz, in_word.invalid};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/disparity_to_point_reprojection_top.sv @@
// Top level of the disparity to point reprojection pipeline.
//
// One pixel word enters on the s_ stream and one point word leaves on the
// m_ stream for each. X, Y and Z are signed Q16.16 meters computed as
// offset * baseline / disparity with truncation toward zero and clipping.
// A word is taken when s_tvalid and s_tready are high at a clock edge.
// There are two front stages (offsets, then products), 36 restoring
// division stages that each resolve one quotient bit of all three
// coordinates, and the clipping stage that is the output register; the
// division chain sets the depth. Throughput is one word per cycle, but
// when the receiver holds m_tready low while m_tvalid is high, the whole
// pipeline freezes and s_tready drops in the same cycle; nothing is lost
// or repeated. Synchronous reset empties the pipeline and loads the
// register defaults. Registers must be written through cfg_we, cfg_index
// and cfg_data only while the pipeline is empty; this is not enforced.
`default_nettype none
module disparity_to_point_reprojection_top import rpj_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // col[11:0], row[23:12], disparity[39:24], intensity[47:40]
  input  wire logic [47:0]         s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // x_pos[31:0], y_pos[63:32], z_pos[95:64], col_out[107:96],
  // row_out[119:108], disparity_out[135:120], intensity_out[143:136]
  output logic [143:0]             m_tdata,
  // invalid[0], saturated[1]
  output logic [1:0]               m_tuser,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cfg_t  cfg;
  logic  adv;
  logic  v   [NumW+1];
  pipe_t w   [NumW+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal <= 16'd8000;
      cfg.ccol  <= 16'd5120;
      cfg.crow  <= 16'd3840;
      cfg.base  <= 20'd7864;
      cfg.invd  <= -16'sd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL: cfg.focal <= cfg_data[15:0];
        REG_CCOL:  cfg.ccol  <= cfg_data[15:0];
        REG_CROW:  cfg.crow  <= cfg_data[15:0];
        REG_BASE:  cfg.base  <= cfg_data;
        REG_INVD:  cfg.invd  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is free.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  rpj_front u_front (
    .clk, .rst, .adv,
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .cfg,
    .out_valid(v[0]),
    .out_word (w[0])
  );

  // Division chain, one quotient bit per stage.
  for (genvar i = 0; i < NumW; i++) begin : g_div
    rpj_div_step u_step (
      .clk, .rst, .adv,
      .in_valid (v[i]),
      .in_word  (w[i]),
      .out_valid(v[i+1]),
      .out_word (w[i+1])
    );
  end

  rpj_sat u_sat (
    .clk, .rst, .adv,
    .in_valid (v[NumW]),
    .in_word  (w[NumW]),
    .out_valid(m_tvalid),
    .out_data (m_tdata),
    .out_user (m_tuser)
  );

endmodule
`default_nettype wire

@@ hw/rtl/rpj_checker.sv @@
// Port-level checks of the reprojection block, bound to the top level.
`default_nettype none
module rpj_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [143:0] m_tdata,
  input wire logic [1:0]   m_tuser
);

  // A held word stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // The input side stalls exactly when a finished word is held.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  // A missing match always reports saturation.
  a_inv_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[1])
    else $error("invalid word without saturated flag");

  // A missing match carries clipped positive coordinates.
  a_inv_val: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'h7FFFFFFF &&
      m_tdata[63:32] == 32'h7FFFFFFF && m_tdata[95:64] == 32'h7FFFFFFF)
    else $error("invalid word with unclipped coordinates");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind disparity_to_point_reprojection_top rpj_checker u_rpj_checker (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
`default_nettype wire
